>>> sv/spdd_pkg.sv
`default_nettype none
package spdd_pkg;

  localparam int MaxPacketBits = 2048;
  localparam int HeaderBits    = 16;
  localparam int FlagBits      = 8;
  localparam int ReservedBits  = 16;
  localparam int BundleCount   = 32;
  localparam int ChanCount     = 96;

  localparam int PtrW = $clog2(MaxPacketBits);
  localparam int LenW = 12;

  localparam logic [LenW-1:0] MaxLen = LenW'(MaxPacketBits);
  localparam logic [5:0] DataStart12 = 6'(HeaderBits + FlagBits);
  localparam logic [5:0] DataStart16 = 6'(HeaderBits + FlagBits + ReservedBits);
  localparam logic [LenW-1:0] Need12 = LenW'(HeaderBits + FlagBits + BundleCount * 36);
  localparam logic [LenW-1:0] Need16 =
    LenW'(HeaderBits + FlagBits + ReservedBits + BundleCount * 48);
  localparam logic [PtrW-1:0] HeaderEnd = PtrW'(HeaderBits - 1);
  localparam logic [4:0] LastBundle = 5'(BundleCount - 1);
  localparam logic [1:0] LastChan = 2'd2;

  localparam logic        SampleModeReset  = 1'b1;
  localparam logic [11:0] PacketBitsReset  = 12'd1600;
  localparam logic [15:0] SyncPatternReset = 16'h0505;

  typedef enum logic [1:0] {
    SyncHunt   = 2'd0,
    SyncLock   = 2'd1,
    SyncSearch = 2'd2
  } sync_state_e;

  typedef enum logic [1:0] {
    RegSampleMode  = 2'd0,
    RegPacketBits  = 2'd1,
    RegSyncPattern = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        sample_mode;
    logic [11:0] packet_bits;
    logic [15:0] sync_pattern;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  channel;
    logic [15:0] sample;
    logic        last_in_packet;
    logic        resynced;
  } res_t;

  // Packet length clipped to the delay line and raised to what the mode needs.
  function automatic logic [LenW-1:0] eff_length(cfg_t c);
    logic [LenW-1:0] len;
    logic [LenW-1:0] need;
    len  = (c.packet_bits > MaxLen) ? MaxLen : c.packet_bits;
    need = c.sample_mode ? Need16 : Need12;
    if (len < need) len = need;
    return len;
  endfunction

  // Exact for every 11-bit argument.
  function automatic logic [9:0] div3_11(logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd683;
    return p[20:11];
  endfunction

  // Exact for every 7-bit argument.
  function automatic logic [5:0] div3_7(logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd86;
    return p[13:8];
  endfunction

endpackage
`default_nettype wire

>>> sv/spdd_bit_if.sv
`default_nettype none
interface spdd_bit_if;
  logic valid;
  logic ready;
  logic data_bit;

  modport source (output valid, output data_bit, input ready);
  modport sink (input valid, input data_bit, output ready);
endinterface
`default_nettype wire

>>> sv/spdd_res_if.sv
`default_nettype none
interface spdd_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  channel;
  logic [15:0] sample;
  logic        last_in_packet;
  logic        resynced;

  modport source (output valid, output channel, output sample, output last_in_packet,
                  output resynced, input ready);
  modport sink (input valid, input channel, input sample, input last_in_packet,
                input resynced, output ready);
endinterface
`default_nettype wire

>>> sv/spdd_ram.sv
`default_nettype none
module spdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/spdd_cfg_regs.sv
`default_nettype none
module spdd_cfg_regs
  import spdd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  output      cfg_t        cfg_o,
  output      cfg_t        cfg_next_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegSampleMode:  cfg_d.sample_mode  = pwdata[0];
        RegPacketBits:  cfg_d.packet_bits  = pwdata[11:0];
        RegSyncPattern: cfg_d.sync_pattern = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegSampleMode:  prdata = {31'd0, cfg_q.sample_mode};
      RegPacketBits:  prdata = {20'd0, cfg_q.packet_bits};
      RegSyncPattern: prdata = {16'd0, cfg_q.sync_pattern};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_mode  <= SampleModeReset;
      cfg_q.packet_bits  <= PacketBitsReset;
      cfg_q.sync_pattern <= SyncPatternReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o      = cfg_q;
  assign cfg_next_o = cfg_d;

endmodule
`default_nettype wire

>>> sv/spdd_core.sv
`default_nettype none
module spdd_core
  import spdd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire cfg_t cfg_next_i,
  input  wire logic accept_i,
  input  wire logic data_bit_i,
  output      logic res_valid_o,
  output      res_t res_o
);

  sync_state_e     st_q, st_d;
  logic [15:0]     hw_q, hw_d, hw_new;
  logic [PtrW-1:0] bp_q, bp_d;
  logic [PtrW-1:0] srch_q, srch_d;
  logic            resync_q, resync_d;
  logic [PtrW-1:0] wr_q, wr_d;
  logic [LenW-1:0] fill_q, fill_d;
  logic [15:0]     acc_q [3];
  logic [15:0]     acc_d [3];

  logic [LenW-1:0] len, len_next;
  logic [PtrW-1:0] raddr;
  logic [15:0]     rdata, delayed;
  logic [LenW-1:0] bp_inc, sc_inc;
  logic [PtrW-1:0] bp_new;
  logic [5:0]      ds;
  logic [LenW-1:0] need;
  logic            in_range;
  logic [PtrW-1:0] rel;
  logic [9:0]      t3;
  logic [1:0]      ch;
  logic [5:0]      q12;
  logic [3:0]      bidx;
  logic [4:0]      bundle;
  logic            complete;
  logic [15:0]     acc_sel, acc_new;

  assign len      = eff_length(cfg_i);
  assign len_next = eff_length(cfg_next_i);
  assign hw_new   = {hw_q[14:0], data_bit_i};

  // Each entry holds the header window as it stood after one bit, so the
  // window that ended one packet ago is a single read. The address is
  // formed from next-cycle values so the registered read is always current.
  assign raddr = wr_d - len_next[PtrW-1:0];

  spdd_ram #(
    .WIDTH (16),
    .DEPTH (MaxPacketBits)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (accept_i),
    .waddr_i (wr_q),
    .wdata_i (hw_new),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Entries older than the bits seen since reset read as zero.
  assign delayed = (fill_q >= len) ? rdata : 16'd0;

  // Slot decode of the new bit position.
  always_comb begin
    bp_inc   = {1'b0, bp_q} + 1'b1;
    bp_new   = (bp_inc >= len) ? '0 : bp_inc[PtrW-1:0];
    ds       = cfg_i.sample_mode ? DataStart16 : DataStart12;
    need     = cfg_i.sample_mode ? Need16 : Need12;
    in_range = (bp_new >= PtrW'(ds)) && ({1'b0, bp_new} < need);
    rel      = bp_new - PtrW'(ds);
    t3       = div3_11(rel);
    ch       = 2'(rel - PtrW'({t3, 1'b0}) - PtrW'(t3));
    q12      = div3_7(t3[8:2]);
    if (cfg_i.sample_mode) begin
      bidx     = t3[3:0];
      bundle   = t3[8:4];
      complete = (bidx == 4'd15);
    end else begin
      bidx     = 4'(t3 - 10'({q12, 3'b000}) - 10'({q12, 2'b00}));
      bundle   = q12[4:0];
      complete = (bidx == 4'd11);
    end
    case (ch)
      2'd0:    acc_sel = acc_q[0];
      2'd1:    acc_sel = acc_q[1];
      default: acc_sel = acc_q[2];
    endcase
    acc_new = {acc_sel[14:0], data_bit_i};
  end

  always_comb begin
    st_d     = st_q;
    hw_d     = hw_q;
    bp_d     = bp_q;
    srch_d   = srch_q;
    resync_d = resync_q;
    wr_d     = wr_q;
    fill_d   = fill_q;
    acc_d    = acc_q;
    sc_inc   = {1'b0, srch_q} + 1'b1;
    res_valid_o          = 1'b0;
    res_o.channel        = 7'({2'b00, bundle} * 7'd3) + 7'(ch);
    res_o.sample         = cfg_i.sample_mode ? acc_new : {{4{acc_new[11]}}, acc_new[11:0]};
    res_o.last_in_packet = (bundle == LastBundle) && (ch == LastChan);
    res_o.resynced       = resync_q;
    if (accept_i) begin
      hw_d = hw_new;
      wr_d = wr_q + 1'b1;
      if (fill_q != '1) fill_d = fill_q + 1'b1;
      case (st_q)
        SyncLock: begin
          bp_d = bp_new;
          if (bp_new == HeaderEnd) begin
            if (hw_new != cfg_i.sync_pattern) begin
              st_d   = SyncSearch;
              srch_d = '0;
            end else begin
              resync_d = 1'b0;
            end
          end
          if (in_range) begin
            case (ch)
              2'd0:    acc_d[0] = acc_new;
              2'd1:    acc_d[1] = acc_new;
              default: acc_d[2] = acc_new;
            endcase
            res_valid_o = complete;
          end
        end
        SyncSearch: begin
          if (hw_new == cfg_i.sync_pattern) begin
            st_d     = SyncLock;
            bp_d     = HeaderEnd;
            resync_d = 1'b1;
            srch_d   = '0;
          end else if (sc_inc >= len) begin
            st_d   = SyncHunt;
            srch_d = '0;
          end else begin
            srch_d = sc_inc[PtrW-1:0];
          end
        end
        default: begin
          if (hw_new == cfg_i.sync_pattern && delayed == cfg_i.sync_pattern) begin
            st_d     = SyncLock;
            bp_d     = HeaderEnd;
            resync_d = 1'b0;
          end else begin
            st_d = SyncHunt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= SyncHunt;
      hw_q     <= '0;
      bp_q     <= '0;
      srch_q   <= '0;
      resync_q <= 1'b0;
      wr_q     <= '0;
      fill_q   <= '0;
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
    end else begin
      st_q     <= st_d;
      hw_q     <= hw_d;
      bp_q     <= bp_d;
      srch_q   <= srch_d;
      resync_q <= resync_d;
      wr_q     <= wr_d;
      fill_q   <= fill_d;
      acc_q    <= acc_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/spdd_out_buf.sv
`default_nettype none
module spdd_out_buf
  import spdd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire res_t in_data_i,
  output      logic space_o,
  output      logic out_valid_o,
  output      res_t out_data_o,
  input  wire logic out_ready_i
);

  logic out_v_q, out_v_d;
  logic skid_v_q, skid_v_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;

  // New requests are taken while the skid entry is free.
  assign space_o = ~skid_v_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q || out_ready_i) begin
      out_v_d  = skid_v_q | in_valid_i;
      out_d    = skid_v_q ? skid_q : in_data_i;
      skid_v_d = 1'b0;
    end else if (in_valid_i) begin
      skid_v_d = 1'b1;
      skid_d   = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> sv/serial_packet_deframer_decoder_unit.sv
`default_nettype none
// Serial packet deframer and decoder. One line bit is taken per clock while
// bit requests are not refused, and the decoded sample from the bit that
// completes it is registered into an output register backed by one skid entry;
// bit requests are refused only while both of those hold samples. The header
// window after every bit is kept in a 2048 x 16 synchronous RAM, so the
// window one packet back is one read per bit; that RAM port sets the one bit
// per clock figure. The RAM needs no clearing pass after reset: a fill count
// makes entries not yet written read as zero. Registers are at byte
// addresses 0 (sample mode), 4 (packet length) and 8 (sync pattern).
module serial_packet_deframer_decoder_unit
  import spdd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  spdd_bit_if.sink         bits_i,
  spdd_res_if.source       res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  cfg_t cfg, cfg_next;
  logic accept;
  logic space;
  logic core_valid;
  res_t core_res;
  res_t out_res;

  spdd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg_o      (cfg),
    .cfg_next_o (cfg_next)
  );

  assign bits_i.ready = space;
  assign accept       = bits_i.valid & space;

  spdd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cfg_next_i  (cfg_next),
    .accept_i    (accept),
    .data_bit_i  (bits_i.data_bit),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  spdd_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (core_valid),
    .in_data_i   (core_res),
    .space_o     (space),
    .out_valid_o (res_o.valid),
    .out_data_o  (out_res),
    .out_ready_i (res_o.ready)
  );

  assign res_o.channel        = out_res.channel;
  assign res_o.sample         = out_res.sample;
  assign res_o.last_in_packet = out_res.last_in_packet;
  assign res_o.resynced       = out_res.resynced;

endmodule
`default_nettype wire
